/* hdl/scancode_key_event_mapper_core_defines.svh */
// Assertion macros shared by the scancode key event mapper RTL.
`ifndef SCANCODE_KEY_EVENT_MAPPER_CORE_DEFINES_SVH
`define SCANCODE_KEY_EVENT_MAPPER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// A property that must hold at every clock edge outside reset.
`define SKM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// A condition that must be followed by another one on the next edge.
`define SKM_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define SKM_ASSERT(label, clk, rst, prop, msg)
`define SKM_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif

`endif

/* hdl/skm_pkg.sv */
// Types, constants and codes shared by the scancode key event mapper.
package skm_pkg;

   // Sizes.
   localparam int QUEUE_DEPTH_DEF = 8;
   localparam int SCAN_CODES      = 128;
   localparam int BINDINGS        = 10;
   localparam int BIND_PER_REG    = 5;
   localparam int CODE_W          = 7;
   localparam int KEY_W           = 9;
   localparam int FLAG_W          = 10;
   localparam int FLAG_IDX_W      = $clog2(FLAG_W);
   localparam int ACTION_W        = 2;
   localparam int BYTE_W          = 8;
   localparam int COUNT_W         = 3;
   localparam int SCAN_REG_W      = 35;
   localparam int KEY_REG_W       = 45;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 45;

   // Actions.
   localparam logic [ACTION_W-1:0] ACT_SCAN  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_TAKE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_BIND_SCAN_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIND_SCAN_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIND_KEYS_LOW  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIND_KEYS_HIGH = 2'd3;

   // Byte-level codes.
   localparam logic [BYTE_W-1:0] PREFIX_BYTE = 8'hE0;
   localparam int                BREAK_BIT   = 7;

   // Scan codes with a fixed meaning.
   localparam logic [CODE_W-1:0] SC_CTRL      = 7'h1D;
   localparam logic [CODE_W-1:0] SC_UP        = 7'h48;
   localparam logic [CODE_W-1:0] SC_UP_ALT    = 7'h11;
   localparam logic [CODE_W-1:0] SC_DOWN      = 7'h50;
   localparam logic [CODE_W-1:0] SC_DOWN_ALT  = 7'h1F;
   localparam logic [CODE_W-1:0] SC_LEFT      = 7'h4B;
   localparam logic [CODE_W-1:0] SC_LEFT_ALT  = 7'h1E;
   localparam logic [CODE_W-1:0] SC_RIGHT     = 7'h4D;
   localparam logic [CODE_W-1:0] SC_RIGHT_ALT = 7'h20;
   localparam logic [CODE_W-1:0] SC_FIRE      = 7'h39;
   localparam logic [CODE_W-1:0] SC_P2_FIRE   = 7'h0F;
   localparam logic [CODE_W-1:0] SC_ESCAPE    = 7'h01;
   localparam logic [CODE_W-1:0] SC_Q         = 7'h10;
   localparam logic [CODE_W-1:0] SC_P         = 7'h19;
   localparam logic [CODE_W-1:0] SC_N         = 7'h31;
   localparam logic [CODE_W-1:0] SC_C         = 7'h2E;

   // Held flag positions.
   localparam logic [FLAG_IDX_W-1:0] FLAG_RIGHT   = 4'd0;
   localparam logic [FLAG_IDX_W-1:0] FLAG_UP      = 4'd1;
   localparam logic [FLAG_IDX_W-1:0] FLAG_LEFT    = 4'd2;
   localparam logic [FLAG_IDX_W-1:0] FLAG_DOWN    = 4'd3;
   localparam logic [FLAG_IDX_W-1:0] FLAG_FIRE    = 4'd4;
   localparam logic [FLAG_IDX_W-1:0] FLAG_P2_FIRE = 4'd9;

   // Queued key codes.
   localparam logic [KEY_W-1:0] KEY_RIGHT    = 9'h14D;
   localparam logic [KEY_W-1:0] KEY_UP       = 9'h148;
   localparam logic [KEY_W-1:0] KEY_LEFT     = 9'h14B;
   localparam logic [KEY_W-1:0] KEY_DOWN     = 9'h150;
   localparam logic [KEY_W-1:0] KEY_FIRE     = 9'h13B;
   localparam logic [KEY_W-1:0] KEY_P2_SHOOT = 9'd9;
   localparam logic [KEY_W-1:0] KEY_QUIT     = 9'd324;
   localparam logic [KEY_W-1:0] KEY_FREEZE   = 9'd32;
   localparam logic [KEY_W-1:0] KEY_ASCII_N  = 9'h06E;
   localparam logic [KEY_W-1:0] KEY_ASCII_C  = 9'h063;

   // Unpacked binding table as seen by the decoder.
   typedef struct packed {
      logic [BINDINGS-1:0][CODE_W-1:0] scan;
      logic [BINDINGS-1:0][KEY_W-1:0]  key;
   } bind_cfg_type;

   // Decoder verdict for one scan code.
   typedef struct packed {
      logic                  flag_hit;
      logic [FLAG_IDX_W-1:0] flag_idx;
      logic                  push;
      logic [KEY_W-1:0]      key;
   } dec_type;

endpackage

/* hdl/skm_req_if.sv */
// Request channel: one action beat with an optional scan byte.
interface skm_req_if import skm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [BYTE_W-1:0]   scan_byte;

   modport source (output valid, output action, output scan_byte, input ready);
   modport sink   (input valid, input action, input scan_byte, output ready);
endinterface

/* hdl/skm_rsp_if.sv */
// Response channel: one status beat per request beat.
interface skm_rsp_if import skm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               event_valid;
   logic [KEY_W-1:0]   event_key;
   logic [FLAG_W-1:0]  held_keys;
   logic [COUNT_W-1:0] queue_count;
   logic               dropped;
   logic               ctrl_held;

   modport source (output valid, output event_valid, output event_key, output held_keys,
                   output queue_count, output dropped, output ctrl_held, input ready);
   modport sink   (input valid, input event_valid, input event_key, input held_keys,
                   input queue_count, input dropped, input ctrl_held, output ready);
endinterface

/* hdl/skm_csr_if.sv */
// Configuration write channel: register index and write data.
interface skm_csr_if import skm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/scancode_key_event_mapper_core.sv */
// Top level of the set-1 scancode decoder with its key event queue.
//
// Usage: each request beat carries an action. A scan action feeds one raw
// set-1 byte (the 0xE0 prefix is ignored), a take action pops the oldest
// queued key, a clear action drops all key state and the queue but keeps
// the binding registers. Every request beat yields exactly one response
// beat with the popped key (if any), the ten held flags, the queue fill,
// a drop flag and the Ctrl state after that request.
// The binding registers are written over the csr channel, which is always
// ready; write it only while no request is in flight.
// A taken request beat goes to the request register, then its response
// beat to the response register, where it turns valid. Throughput: one
// beat per cycle while the response side keeps up; the key state and
// queue pointers update in the single decode stage between the two
// registers. When the response side stalls, the response register holds
// its beat and the request register still takes one more beat; request
// ready then drops until the response is taken.
// Reset (synchronous, active high) empties both registers, clears the down
// map valid bits, held flags, Ctrl, queue pointers and binding registers.
`include "scancode_key_event_mapper_core_defines.svh"

module scancode_key_event_mapper_core import skm_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   skm_req_if.sink   req_ch,
   skm_rsp_if.source rsp_ch,
   skm_csr_if.sink   csr_ch
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;
   localparam int LAST_PTR = QUEUE_DEPTH - 1;

   // Next slot in the ring, wrapping at the depth.
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      n = (p == PTR_W'(LAST_PTR)) ? '0 : p + PTR_W'(1);
      return n;
   endfunction

   // Request stage.
   logic                s1_valid_ff, s1_valid_in;
   logic [ACTION_W-1:0] s1_action_ff;
   logic [BYTE_W-1:0]   s1_byte_ff;
   logic                accept, advance;

   // Decode stage.
   logic                s1_scan, s1_take, s1_clear;
   logic [CODE_W-1:0]   code;
   logic                make, prev_down;
   bind_cfg_type        cfg;
   dec_type             dec;

   // Down map.
   logic [SCAN_CODES-1:0] cd_valid_ff, cd_valid_in;
   logic                  cd_rdata, cd_we;
   logic                  cd_byp_hit_ff, cd_byp_data_ff;

   // Key state.
   logic [FLAG_W-1:0] held_ff, held_in;
   logic              ctrl_ff, ctrl_in;

   // Event ring.
   logic [PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic             full, ring_we, drop, take;
   logic [KEY_W-1:0] ring_rdata, ring_head;
   logic             rg_byp_hit_ff;
   logic [KEY_W-1:0] rg_byp_data_ff;
   logic [CNT_W-1:0] cnt_sum, cnt;
   logic [CNT_W+COUNT_W-1:0] cnt_ext;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_event_valid_ff;
   logic [KEY_W-1:0]   rsp_event_key_ff;
   logic [FLAG_W-1:0]  rsp_held_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_dropped_ff;
   logic               rsp_ctrl_ff;

   // Configuration registers.
   assign csr_ch.ready = 1'b1;

   skm_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   // Handshake: the request stage moves on whenever the response slot frees up.
   assign advance      = s1_valid_ff & (~rsp_valid_ff | rsp_ch.ready);
   assign req_ch.ready = ~s1_valid_ff | advance;
   assign accept       = req_ch.valid & req_ch.ready;
   assign s1_valid_in  = accept | (s1_valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff <= req_ch.action;
         s1_byte_ff   <= req_ch.scan_byte;
      end
   end

   // Split the byte into code and make or break.
   assign code     = s1_byte_ff[CODE_W-1:0];
   assign make     = ~s1_byte_ff[BREAK_BIT];
   assign s1_scan  = advance & (s1_action_ff == ACT_SCAN) & (s1_byte_ff != PREFIX_BYTE);
   assign s1_take  = advance & (s1_action_ff == ACT_TAKE);
   assign s1_clear = advance & (s1_action_ff == ACT_CLEAR);

   // Down map: data in RAM, read when the beat is taken; valid bits in flops.
   assign cd_we = s1_scan;

   skm_ram #(
      .WIDTH (1),
      .DEPTH (SCAN_CODES)
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (cd_we),
      .wr_addr (code),
      .wr_data (make),
      .rd_en   (accept),
      .rd_addr (req_ch.scan_byte[CODE_W-1:0]),
      .rd_data (cd_rdata)
   );

   // Forward a write that lands in the same cycle as the read.
   always_ff @(posedge clock) begin
      if (reset) begin
         cd_byp_hit_ff <= 1'b0;
      end else if (accept) begin
         cd_byp_hit_ff <= cd_we & (code == req_ch.scan_byte[CODE_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cd_byp_data_ff <= make;
      end
   end

   assign prev_down = cd_valid_ff[code] & (cd_byp_hit_ff ? cd_byp_data_ff : cd_rdata);

   always_comb begin
      cd_valid_in = cd_valid_ff;
      if (s1_clear) begin
         cd_valid_in = '0;
      end else if (cd_we) begin
         cd_valid_in[code] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cd_valid_ff <= '0;
      end else begin
         cd_valid_ff <= cd_valid_in;
      end
   end

   // Key decode.
   skm_decode u_decode (
      .code      (code),
      .make      (make),
      .prev_down (prev_down),
      .ctrl      (ctrl_ff),
      .held      (held_ff),
      .cfg       (cfg),
      .dec       (dec)
   );

   // Held flags and Ctrl.
   always_comb begin
      held_in = held_ff;
      ctrl_in = ctrl_ff;
      if (s1_clear) begin
         held_in = '0;
         ctrl_in = 1'b0;
      end else if (s1_scan) begin
         if (dec.flag_hit) begin
            held_in[dec.flag_idx] = make;
         end
         if (code == SC_CTRL) begin
            ctrl_in = make;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         ctrl_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
         ctrl_ff <= ctrl_in;
      end
   end

   // Ring pointers; one slot stays free so full and empty differ.
   assign full    = (ptr_next(wp_ff) == rp_ff);
   assign ring_we = s1_scan & dec.push & ~full;
   assign drop    = s1_scan & dec.push & full;
   assign take    = s1_take & (rp_ff != wp_ff);

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (s1_clear) begin
         wp_in = '0;
         rp_in = '0;
      end else begin
         if (ring_we) begin
            wp_in = ptr_next(wp_ff);
         end
         if (take) begin
            rp_in = ptr_next(rp_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
   end

   // Ring storage; the head slot is prefetched at the next read pointer.
   skm_ram #(
      .WIDTH (KEY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (wp_ff),
      .wr_data (dec.key),
      .rd_en   (1'b1),
      .rd_addr (rp_in),
      .rd_data (ring_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rg_byp_hit_ff <= 1'b0;
      end else begin
         rg_byp_hit_ff <= ring_we & (wp_ff == rp_in);
      end
   end

   always_ff @(posedge clock) begin
      rg_byp_data_ff <= dec.key;
   end

   assign ring_head = rg_byp_hit_ff ? rg_byp_data_ff : ring_rdata;

   // Fill level after this beat.
   always_comb begin
      cnt_sum = {1'b0, wp_in} + CNT_W'(QUEUE_DEPTH) - {1'b0, rp_in};
      cnt     = (cnt_sum >= CNT_W'(QUEUE_DEPTH)) ? cnt_sum - CNT_W'(QUEUE_DEPTH) : cnt_sum;
      cnt_ext = {{COUNT_W{1'b0}}, cnt};
   end

   // Response register.
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_event_valid_ff <= take;
         rsp_event_key_ff   <= take ? ring_head : '0;
         rsp_held_ff        <= held_in;
         rsp_count_ff       <= cnt_ext[COUNT_W-1:0];
         rsp_dropped_ff     <= drop;
         rsp_ctrl_ff        <= ctrl_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.event_valid = rsp_event_valid_ff;
   assign rsp_ch.event_key   = rsp_event_key_ff;
   assign rsp_ch.held_keys   = rsp_held_ff;
   assign rsp_ch.queue_count = rsp_count_ff;
   assign rsp_ch.dropped     = rsp_dropped_ff;
   assign rsp_ch.ctrl_held   = rsp_ctrl_ff;

   // Checks.
   `SKM_ASSERT(a_ready_only_when_full, clock, reset,
      !req_ch.ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ch.ready),
      "request stalled without a full pipeline")
   `SKM_ASSERT(a_no_write_and_pop, clock, reset,
      !(ring_we && take), "ring written and popped in one beat")
   `SKM_ASSERT(a_drop_not_on_take, clock, reset,
      (rsp_valid_ff && rsp_dropped_ff) |-> !rsp_event_valid_ff, "drop reported on a take beat")
   `SKM_ASSERT_NEXT(a_pop_moves_pointer, clock, reset,
      take && !s1_clear, rp_ff != $past(rp_ff), "pop did not move the read pointer")

endmodule

/* hdl/skm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module skm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; a read of the address being written returns the old word.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/skm_csr.sv */
// Binding registers and their unpacking into a per-binding table.
module skm_csr import skm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [CSR_INDEX_W-1:0] wr_index,
   input  logic [CSR_DATA_W-1:0]  wr_data,
   output bind_cfg_type           cfg
);

   logic [SCAN_REG_W-1:0] scan_low_ff, scan_high_ff;
   logic [KEY_REG_W-1:0]  keys_low_ff, keys_high_ff;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_low_ff  <= '0;
         scan_high_ff <= '0;
         keys_low_ff  <= '0;
         keys_high_ff <= '0;
      end else if (wr_en) begin
         unique case (wr_index)
            CSR_BIND_SCAN_LOW:  scan_low_ff  <= wr_data[SCAN_REG_W-1:0];
            CSR_BIND_SCAN_HIGH: scan_high_ff <= wr_data[SCAN_REG_W-1:0];
            CSR_BIND_KEYS_LOW:  keys_low_ff  <= wr_data[KEY_REG_W-1:0];
            CSR_BIND_KEYS_HIGH: keys_high_ff <= wr_data[KEY_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // The first five bindings live in the low registers, the rest in the high ones.
   always_comb begin
      for (int i = 0; i < BINDINGS; i++) begin
         if (i < BIND_PER_REG) begin
            cfg.scan[i] = scan_low_ff[CODE_W*i +: CODE_W];
            cfg.key[i]  = keys_low_ff[KEY_W*i +: KEY_W];
         end else begin
            cfg.scan[i] = scan_high_ff[CODE_W*(i-BIND_PER_REG) +: CODE_W];
            cfg.key[i]  = keys_high_ff[KEY_W*(i-BIND_PER_REG) +: KEY_W];
         end
      end
   end

endmodule

/* hdl/skm_decode.sv */
// Maps one make or break code to a held flag or a queued key.
module skm_decode import skm_pkg::*; (
   input  logic [CODE_W-1:0] code,
   input  logic              make,
   input  logic              prev_down,
   input  logic              ctrl,
   input  logic [FLAG_W-1:0] held,
   input  bind_cfg_type      cfg,
   output dec_type           dec
);

   logic                  alias_hit;
   logic [FLAG_IDX_W-1:0] alias_idx;
   logic [KEY_W-1:0]      alias_key;
   logic                  bind_hit;
   logic [FLAG_IDX_W-1:0] bind_idx;
   logic [KEY_W-1:0]      bind_key;
   logic [KEY_W-1:0]      plain_key;

   // Fixed aliases for the arrow keys, fire and player two fire.
   always_comb begin
      alias_hit = 1'b1;
      alias_idx = FLAG_RIGHT;
      alias_key = KEY_RIGHT;
      unique case (code) inside
         SC_UP, SC_UP_ALT: begin
            alias_idx = FLAG_UP;
            alias_key = KEY_UP;
         end
         SC_DOWN, SC_DOWN_ALT: begin
            alias_idx = FLAG_DOWN;
            alias_key = KEY_DOWN;
         end
         SC_LEFT, SC_LEFT_ALT: begin
            alias_idx = FLAG_LEFT;
            alias_key = KEY_LEFT;
         end
         SC_RIGHT, SC_RIGHT_ALT: begin
            alias_idx = FLAG_RIGHT;
            alias_key = KEY_RIGHT;
         end
         SC_FIRE: begin
            alias_idx = FLAG_FIRE;
            alias_key = KEY_FIRE;
         end
         SC_P2_FIRE: begin
            alias_idx = FLAG_P2_FIRE;
            alias_key = KEY_P2_SHOOT;
         end
         default: alias_hit = 1'b0;
      endcase
   end

   // Configured bindings: the lowest matching binding wins, so scan downward.
   always_comb begin
      bind_hit = 1'b0;
      bind_idx = '0;
      bind_key = '0;
      for (int i = BINDINGS - 1; i >= 0; i--) begin
         if (code == cfg.scan[i]) begin
            bind_hit = 1'b1;
            bind_idx = FLAG_IDX_W'(i);
            bind_key = cfg.key[i];
         end
      end
   end

   // Keys for codes that drive no flag.
   always_comb begin
      unique case (code) inside
         SC_ESCAPE, SC_Q: plain_key = KEY_QUIT;
         SC_P:            plain_key = KEY_FREEZE;
         SC_N:            plain_key = KEY_ASCII_N;
         SC_C:            plain_key = ctrl ? KEY_QUIT : KEY_ASCII_C;
         default:         plain_key = {{(KEY_W-CODE_W){1'b0}}, code};
      endcase
   end

   // A flag queues its key on a fresh set; other codes queue on a fresh make.
   always_comb begin
      dec.flag_hit = alias_hit | bind_hit;
      dec.flag_idx = alias_hit ? alias_idx : bind_idx;
      if (alias_hit | bind_hit) begin
         dec.key  = alias_hit ? alias_key : bind_key;
         dec.push = make & ~held[dec.flag_idx];
      end else begin
         dec.key  = plain_key;
         dec.push = make & ~prev_down;
      end
   end

endmodule
